### src/source_tokenizer_macros.svh
// Assertion macros for the source tokenizer checker.
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH

// Overlapping implication, sampled on clk, off during reset.
`define ST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle, sampled on clk, off during reset.
`define ST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/st_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package st_pkg;

  localparam int unsigned POS_BITS        = 16;
  localparam int unsigned KW_MAX_LEN      = 7;
  localparam int unsigned IDX_BITS        = $clog2(KW_MAX_LEN);
  localparam int unsigned WLEN_BITS       = $clog2(KW_MAX_LEN + 2);
  localparam int unsigned MAX_RES         = 3;

  localparam logic [4:0] K_LBRACE  = 5'd0;
  localparam logic [4:0] K_RBRACE  = 5'd1;
  localparam logic [4:0] K_LPAREN  = 5'd2;
  localparam logic [4:0] K_RPAREN  = 5'd3;
  localparam logic [4:0] K_SEMI    = 5'd4;
  localparam logic [4:0] K_ASSIGN  = 5'd5;
  localparam logic [4:0] K_ARROW   = 5'd6;
  localparam logic [4:0] K_STRING  = 5'd7;
  localparam logic [4:0] K_BUILTIN = 5'd8;
  localparam logic [4:0] K_PROC    = 5'd9;
  localparam logic [4:0] K_STR     = 5'd10;
  localparam logic [4:0] K_INT     = 5'd11;
  localparam logic [4:0] K_VOID    = 5'd12;
  localparam logic [4:0] K_IDENT   = 5'd13;
  localparam logic [4:0] K_NUMBER  = 5'd14;
  localparam logic [4:0] K_END     = 5'd15;
  localparam logic [4:0] K_ERROR   = 5'd16;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHAR     = 2'd1;
  localparam logic [1:0] ERR_DASH     = 2'd2;
  localparam logic [1:0] ERR_UNTERM   = 2'd3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_DASH    = 7'b0000010,
    M_STRING  = 7'b0000100,
    M_COMMENT = 7'b0001000,
    M_WORD    = 7'b0010000,
    M_NUMBER  = 7'b0100000,
    M_DEAD    = 7'b1000000
  } mode_t;

  typedef logic [7:0] prefix_t [KW_MAX_LEN];

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  err;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic [31:0] value;
    logic        last;
  } res_t;

  function automatic res_t mk_res(logic [4:0] kind, logic [1:0] err,
                                  logic [POS_BITS-1:0] s, logic [POS_BITS-1:0] e,
                                  logic [31:0] value);
    res_t r;
    r.kind       = kind;
    r.err        = err;
    r.span_start = 16'(s);
    r.span_end   = 16'(e);
    r.value      = value;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // txt holds the keyword right-aligned, first character in the highest used byte
  function automatic logic kw_eq(prefix_t p, logic [WLEN_BITS-1:0] len,
                                 logic [63:0] txt, int unsigned tl);
    logic m;
    m = (len == WLEN_BITS'(tl));
    for (int unsigned i = 0; i < KW_MAX_LEN; i++) begin
      if (i < tl) m = m & (p[i] == txt[(tl-1-i)*8 +: 8]);
    end
    return m;
  endfunction

  function automatic logic [4:0] kw_kind(prefix_t p, logic [WLEN_BITS-1:0] len);
    logic [4:0] k;
    priority if (kw_eq(p, len, 64'("builtin"), 7)) k = K_BUILTIN;
    else if (kw_eq(p, len, 64'("proc"), 4))        k = K_PROC;
    else if (kw_eq(p, len, 64'("str"), 3))         k = K_STR;
    else if (kw_eq(p, len, 64'("int"), 3))         k = K_INT;
    else if (kw_eq(p, len, 64'("void"), 4))        k = K_VOID;
    else                                           k = K_IDENT;
    return k;
  endfunction

endpackage

`default_nettype wire

### src/source_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Signals                              Direction  Moves
// src      src_valid/src_ready, byte_in, is_last  in       one source byte per transfer
// tok      tok_valid/tok_ready, kind .. last_of_run out    one token per transfer
//
// A byte is lexed in the cycle it is taken; its zero to three tokens land in a
// three-entry result buffer that drains one token per cycle while tok_ready is high.
// One byte per cycle while each byte yields at most one token and tok_ready is high;
// a byte with n > 1 tokens holds the source side until one token is left to drain.
// Synchronous reset clears the mode, position and buffer count.
// src is ready when the buffer is empty, or holds one token that transfers in the same
// cycle; a stalled tok side with any token waiting holds src.

module source_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        src_valid,
  output logic             src_ready,
  input  wire logic [7:0]  byte_in,
  input  wire logic        is_last,
  output logic             tok_valid,
  input  wire logic        tok_ready,
  output logic [4:0]       kind,
  output logic [1:0]       error_code,
  output logic [15:0]      span_start,
  output logic [15:0]      span_end,
  output logic signed [31:0] int_value,
  output logic             last_of_run
);
  import st_pkg::*;

  mode_t                  mode, mode_next;
  logic [POS_BITS-1:0]    pos, pos_next, pos_inc;
  logic [POS_BITS-1:0]    tstart, tstart_next;
  prefix_t                prefix, prefix_next;
  logic [WLEN_BITS-1:0]   wlen, wlen_next;
  logic [31:0]            acc, acc_next;
  res_t                   slot [MAX_RES];
  res_t                   res_next [MAX_RES];
  logic [1:0]             cnt;
  logic [1:0]             n_next;
  logic                   fresh;
  logic                   accept, take;

  assign tok_valid = (cnt != 2'd0);
  assign src_ready = (cnt == 2'd0) || (cnt == 2'd1 && tok_ready);
  assign accept    = src_valid && src_ready;
  assign take      = tok_valid && tok_ready;
  assign pos_inc   = pos + POS_BITS'(1);

  assign kind        = slot[0].kind;
  assign error_code  = slot[0].err;
  assign span_start  = slot[0].span_start;
  assign span_end    = slot[0].span_end;
  assign int_value   = $signed(slot[0].value);
  assign last_of_run = slot[0].last;

  always_comb begin
    mode_next   = mode;
    pos_next    = pos_inc;
    tstart_next = tstart;
    prefix_next = prefix;
    wlen_next   = wlen;
    acc_next    = acc;
    n_next      = 2'd0;
    fresh       = 1'b0;
    for (int i = 0; i < MAX_RES; i++) res_next[i] = '0;

    unique case (mode)
      M_DASH: begin
        if (byte_in == CH_GT) begin
          res_next[n_next] = mk_res(K_ARROW, ERR_NONE, tstart, pos_inc, '0);
          n_next = n_next + 2'd1;
          mode_next = M_IDLE;
        end else begin
          res_next[n_next] = mk_res(K_ERROR, ERR_DASH, tstart, pos_inc, '0);
          n_next = n_next + 2'd1;
          mode_next = M_DEAD;
        end
      end
      M_STRING: begin
        if (byte_in == CH_QUOTE) begin
          res_next[n_next] = mk_res(K_STRING, ERR_NONE, tstart, pos_inc, '0);
          n_next = n_next + 2'd1;
          mode_next = M_IDLE;
        end else if (byte_in == CH_LF) begin
          res_next[n_next] = mk_res(K_ERROR, ERR_UNTERM, tstart, pos, '0);
          n_next = n_next + 2'd1;
          mode_next = M_DEAD;
        end
      end
      M_COMMENT: begin
        if (byte_in == CH_CR) mode_next = M_IDLE;
      end
      M_WORD: begin
        if (is_alpha(byte_in)) begin
          if (wlen < WLEN_BITS'(KW_MAX_LEN)) prefix_next[wlen[IDX_BITS-1:0]] = byte_in;
          if (wlen <= WLEN_BITS'(KW_MAX_LEN)) wlen_next = wlen + WLEN_BITS'(1);
        end else begin
          res_next[n_next] = mk_res(kw_kind(prefix, wlen), ERR_NONE, tstart, pos, '0);
          n_next = n_next + 2'd1;
          mode_next = M_IDLE;
          fresh = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(byte_in)) begin
          acc_next = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + 32'(byte_in - CH_ZERO);
        end else begin
          res_next[n_next] = mk_res(K_NUMBER, ERR_NONE, tstart, pos, acc);
          n_next = n_next + 2'd1;
          mode_next = M_IDLE;
          fresh = 1'b1;
        end
      end
      M_DEAD: begin
      end
      M_IDLE: begin
        fresh = 1'b1;
      end
      default: begin
        mode_next = M_IDLE;
        fresh = 1'b1;
      end
    endcase

    if (fresh) begin
      tstart_next = pos;
      priority if (byte_in == CH_SPACE || byte_in == CH_LF ||
                   byte_in == CH_CR || byte_in == CH_TAB) begin
      end else if (byte_in == CH_LBRACE || byte_in == CH_RBRACE ||
                   byte_in == CH_LPAREN || byte_in == CH_RPAREN ||
                   byte_in == CH_SEMI || byte_in == CH_EQ) begin
        unique case (byte_in)
          CH_LBRACE: res_next[n_next] = mk_res(K_LBRACE, ERR_NONE, pos, pos_inc, '0);
          CH_RBRACE: res_next[n_next] = mk_res(K_RBRACE, ERR_NONE, pos, pos_inc, '0);
          CH_LPAREN: res_next[n_next] = mk_res(K_LPAREN, ERR_NONE, pos, pos_inc, '0);
          CH_RPAREN: res_next[n_next] = mk_res(K_RPAREN, ERR_NONE, pos, pos_inc, '0);
          CH_SEMI:   res_next[n_next] = mk_res(K_SEMI, ERR_NONE, pos, pos_inc, '0);
          default:   res_next[n_next] = mk_res(K_ASSIGN, ERR_NONE, pos, pos_inc, '0);
        endcase
        n_next = n_next + 2'd1;
      end else if (byte_in == CH_DASH) begin
        mode_next = M_DASH;
      end else if (byte_in == CH_QUOTE) begin
        mode_next = M_STRING;
      end else if (byte_in == CH_HASH) begin
        mode_next = M_COMMENT;
      end else if (is_alpha(byte_in)) begin
        prefix_next[0] = byte_in;
        wlen_next = WLEN_BITS'(1);
        mode_next = M_WORD;
      end else if (is_digit(byte_in)) begin
        acc_next = 32'(byte_in - CH_ZERO);
        mode_next = M_NUMBER;
      end else begin
        res_next[n_next] = mk_res(K_ERROR, ERR_CHAR, pos, pos_inc, '0);
        n_next = n_next + 2'd1;
      end
    end

    if (is_last) begin
      unique case (mode_next)
        M_WORD: begin
          res_next[n_next] = mk_res(kw_kind(prefix_next, wlen_next), ERR_NONE,
                                    tstart_next, pos_inc, '0);
          n_next = n_next + 2'd1;
        end
        M_NUMBER: begin
          res_next[n_next] = mk_res(K_NUMBER, ERR_NONE, tstart_next, pos_inc, acc_next);
          n_next = n_next + 2'd1;
        end
        M_STRING: begin
          res_next[n_next] = mk_res(K_ERROR, ERR_UNTERM, tstart_next, pos_inc, '0);
          n_next = n_next + 2'd1;
        end
        M_DASH: begin
          res_next[n_next] = mk_res(K_ERROR, ERR_DASH, tstart_next, pos_inc, '0);
          n_next = n_next + 2'd1;
        end
        default: begin
        end
      endcase
      res_next[n_next] = mk_res(K_END, ERR_NONE, pos_inc, pos_inc, '0);
      n_next = n_next + 2'd1;
      mode_next   = M_IDLE;
      pos_next    = '0;
      tstart_next = '0;
      wlen_next   = '0;
      acc_next    = '0;
    end

    if (n_next != 2'd0) res_next[n_next - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      tstart <= '0;
      wlen   <= '0;
      acc    <= '0;
      cnt    <= 2'd0;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      wlen   <= wlen_next;
      acc    <= acc_next;
      cnt    <= n_next;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prefix <= prefix_next;
      for (int i = 0; i < MAX_RES; i++) slot[i] <= res_next[i];
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) slot[i] <= slot[i+1];
    end
  end

endmodule

`default_nettype wire

### src/st_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "source_tokenizer_macros.svh"

module st_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        src_valid,
  input wire logic        src_ready,
  input wire logic        is_last,
  input wire logic        tok_valid,
  input wire logic        tok_ready,
  input wire logic [4:0]  kind,
  input wire logic [1:0]  error_code,
  input wire logic [15:0] span_start,
  input wire logic [15:0] span_end,
  input wire logic signed [31:0] int_value,
  input wire logic        last_of_run
);
  import st_pkg::*;

  `ST_ASSERT_NEXT(a_tok_hold, tok_valid && !tok_ready,
    tok_valid && $stable(kind) && $stable(span_start) && $stable(span_end),
    "token changed while stalled")
  `ST_ASSERT_NEXT(a_last_gives_token, src_valid && src_ready && is_last, tok_valid,
    "final byte produced no token")
  `ST_ASSERT_NOW(a_end_shape, tok_valid && kind == K_END,
    span_start == span_end && last_of_run && error_code == ERR_NONE,
    "malformed end token")
  `ST_ASSERT_NOW(a_err_code, tok_valid && kind != K_ERROR, error_code == ERR_NONE,
    "error code on non-error token")
  `ST_ASSERT_NOW(a_value_zero, tok_valid && kind != K_NUMBER, int_value == 32'sd0,
    "value on non-integer token")

endmodule

bind source_tokenizer st_checker u_st_checker (.*);

`default_nettype wire
